// ===== rtl/plt_pkg.sv =====
// ============================================================================
// plt_pkg
// Shared widths, codes, state type and control structs of the position
// limit tracker.
// ============================================================================
`default_nettype none

package plt_pkg;

    localparam int SYMBOL_COUNT_DEF   = 256;
    localparam int POSITION_WIDTH_DEF = 48;

    localparam int OP_W       = 2;
    localparam int SYMBOL_W   = 8;
    localparam int QTY_W      = 47;
    localparam int STATUS_W   = 2;
    localparam int MAXPOS_W   = 47;
    localparam int MAXTOT_W   = 55;
    localparam int COUNT_W    = 32;
    localparam int PEAK_W     = 47;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 55;
    localparam int TABLE_MAX  = 2 ** SYMBOL_W;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_op OP_FILL  = 2'd0;
    localparam t_op OP_CLEAR = 2'd1;
    localparam t_op OP_QUERY = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_POS_LIMIT = 2'd1;
    localparam t_status ST_TOT_LIMIT = 2'd2;

    localparam t_cfg_idx CFG_RISK_ON = 2'd0;
    localparam t_cfg_idx CFG_MAX_POS = 2'd1;
    localparam t_cfg_idx CFG_MAX_TOT = 2'd2;

    localparam logic [PEAK_W-1:0]   PEAK_MAX    = '1;
    localparam logic [MAXTOT_W-1:0] TOT_OUT_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ABS,
        S_SUM,
        S_DECIDE,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic stage_new;
        logic stage_abs;
        logic stage_sum;
        logic decide;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/plt_in_if.sv =====
// ============================================================================
// plt_in_if
// Input item channel: operation, symbol, side and quantity.
// ============================================================================
`default_nettype none

interface plt_in_if;
    logic                          valid;
    logic                          ready;
    logic [plt_pkg::OP_W-1:0]      op;
    logic [plt_pkg::SYMBOL_W-1:0]  symbol;
    logic                          side;
    logic [plt_pkg::QTY_W-1:0]     quantity;

    modport source (output valid, output op, output symbol, output side,
                    output quantity, input ready);
    modport sink   (input valid, input op, input symbol, input side,
                    input quantity, output ready);
endinterface

`default_nettype wire

// ===== rtl/plt_out_if.sv =====
// ============================================================================
// plt_out_if
// Result item channel: status, position, totals and emergency stop.
// ============================================================================
`default_nettype none

interface plt_out_if #(
    parameter int POSITION_WIDTH = plt_pkg::POSITION_WIDTH_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic [plt_pkg::STATUS_W-1:0]         status;
    logic signed [POSITION_WIDTH-1:0]     position;
    logic [plt_pkg::MAXTOT_W-1:0]         total_exposure;
    logic                                 emergency_stop;
    logic [plt_pkg::COUNT_W-1:0]          trade_count;
    logic [plt_pkg::PEAK_W-1:0]           peak_position;

    modport source (output valid, output status, output position,
                    output total_exposure, output emergency_stop,
                    output trade_count, output peak_position, input ready);
    modport sink   (input valid, input status, input position,
                    input total_exposure, input emergency_stop,
                    input trade_count, input peak_position, output ready);
endinterface

`default_nettype wire

// ===== rtl/plt_ram.sv =====
// ============================================================================
// plt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
`default_nettype none

module plt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/plt_ctrl.sv =====
// ============================================================================
// plt_ctrl
// Sequencer for the read, check and commit steps of one item.
// ============================================================================
`default_nettype none

module plt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output      logic          o_in_ready,
    input  wire plt_pkg::t_sts i_sts,
    output      plt_pkg::t_cmd o_cmd
);

    plt_pkg::t_state r_state;
    plt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            plt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = plt_pkg::S_LOAD;
                end
            end
            plt_pkg::S_LOAD:   n_state = plt_pkg::S_ABS;
            plt_pkg::S_ABS:    n_state = plt_pkg::S_SUM;
            plt_pkg::S_SUM:    n_state = plt_pkg::S_DECIDE;
            plt_pkg::S_DECIDE: n_state = plt_pkg::S_COMMIT;
            plt_pkg::S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = plt_pkg::S_IDLE;
                end
            end
            default: n_state = plt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            plt_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            plt_pkg::S_LOAD:   o_cmd.stage_new = 1'b1;
            plt_pkg::S_ABS:    o_cmd.stage_abs = 1'b1;
            plt_pkg::S_SUM:    o_cmd.stage_sum = 1'b1;
            plt_pkg::S_DECIDE: o_cmd.decide    = 1'b1;
            plt_pkg::S_COMMIT: o_cmd.commit    = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == plt_pkg::S_LOAD)
        else $error("accepted item did not start the sequence");
    a_commit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == plt_pkg::S_COMMIT && !i_sts.out_free |=>
            r_state == plt_pkg::S_COMMIT)
        else $error("commit left while result register busy");
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

// ===== rtl/plt_datapath.sv =====
// ============================================================================
// plt_datapath
// Position table, limit checks, running totals and result register.
// ============================================================================
`default_nettype none

module plt_datapath #(
    parameter int SYMBOL_COUNT   = plt_pkg::SYMBOL_COUNT_DEF,
    parameter int POSITION_WIDTH = plt_pkg::POSITION_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [plt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [plt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [plt_pkg::OP_W-1:0]          i_op,
    input  wire logic [plt_pkg::SYMBOL_W-1:0]      i_symbol,
    input  wire logic                              i_side,
    input  wire logic [plt_pkg::QTY_W-1:0]         i_quantity,
    input  wire plt_pkg::t_cmd                     i_cmd,
    output      plt_pkg::t_sts                     o_sts,
    plt_out_if.source                              o_rsp
);

    localparam int PW     = POSITION_WIDTH;
    localparam int DEPTH  = (SYMBOL_COUNT < plt_pkg::TABLE_MAX) ? SYMBOL_COUNT
                                                                : plt_pkg::TABLE_MAX;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = ((PW > plt_pkg::QTY_W + 1) ? PW : plt_pkg::QTY_W + 1) + 1;
    localparam int EXP_W  = (PW + plt_pkg::SYMBOL_W < 64) ? PW + plt_pkg::SYMBOL_W : 64;
    localparam int CMP_W  = (EXP_W > plt_pkg::MAXTOT_W) ? EXP_W : plt_pkg::MAXTOT_W;
    localparam int AC_W   = (PW > plt_pkg::MAXPOS_W) ? PW : plt_pkg::MAXPOS_W;

    localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

    // configuration
    logic                          r_risk_on;
    logic [plt_pkg::MAXPOS_W-1:0]  r_max_pos;
    logic [plt_pkg::MAXTOT_W-1:0]  r_max_tot;

    // running state
    logic [DEPTH-1:0]              r_valid;
    logic [EXP_W-1:0]              r_exp;
    logic [plt_pkg::COUNT_W-1:0]   r_count;
    logic [plt_pkg::PEAK_W-1:0]    r_peak;

    // item registers
    plt_pkg::t_op                  r_op;
    logic                          r_side;
    logic [plt_pkg::QTY_W-1:0]     r_qty;
    logic [ADDR_W-1:0]             r_addr;
    logic                          r_in_range;
    logic                          r_vld_rd;
    logic signed [PW-1:0]          r_old;
    logic signed [PW-1:0]          r_new;
    logic [PW-1:0]                 r_aold;
    logic [PW-1:0]                 r_anew;
    logic [EXP_W-1:0]              r_others;
    logic [EXP_W-1:0]              r_tot;
    logic                          r_pos_fail;
    plt_pkg::t_status              r_status;
    logic                          r_is_fill;
    logic                          r_is_clear;

    // result register
    logic                          r_out_valid;
    plt_pkg::t_status              r_out_status;
    logic signed [PW-1:0]          r_out_pos;
    logic [plt_pkg::MAXTOT_W-1:0]  r_out_tot;
    logic                          r_out_estop;
    logic [plt_pkg::COUNT_W-1:0]   r_out_count;
    logic [plt_pkg::PEAK_W-1:0]    r_out_peak;

    logic [31:0]                   sym_ext;
    logic                          in_range_c;
    logic [ADDR_W-1:0]             raddr_c;
    logic [PW-1:0]                 ram_rdata;
    logic signed [PW-1:0]          old_c;
    logic [PW-1:0]                 old_u;
    logic [PW-1:0]                 aold_c;
    logic signed [SUM_W-1:0]       old_x;
    logic signed [SUM_W-1:0]       qty_x;
    logic signed [SUM_W-1:0]       sum_x;
    logic signed [PW-1:0]          fill_c;
    logic [PW-1:0]                 new_u;
    logic                          write_c;
    logic                          fill_ok_c;
    logic [EXP_W-1:0]              n_exp;
    logic [plt_pkg::COUNT_W-1:0]   n_count;
    logic [plt_pkg::PEAK_W-1:0]    n_peak;
    logic [AC_W-1:0]               anew_w;
    logic [plt_pkg::PEAK_W-1:0]    peak_cand;
    logic [CMP_W-1:0]              exp_w;

    assign sym_ext    = 32'(i_symbol);
    assign in_range_c = sym_ext < 32'(SYMBOL_COUNT);
    assign raddr_c    = sym_ext[ADDR_W-1:0];

    plt_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && write_c),
        .i_waddr (r_addr),
        .i_wdata (r_new),
        .i_raddr (raddr_c),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_risk_on <= 1'b0;
            r_max_pos <= '0;
            r_max_tot <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                plt_pkg::CFG_RISK_ON: r_risk_on <= i_cfg_data[0];
                plt_pkg::CFG_MAX_POS: r_max_pos <= i_cfg_data[plt_pkg::MAXPOS_W-1:0];
                plt_pkg::CFG_MAX_TOT: r_max_tot <= i_cfg_data[plt_pkg::MAXTOT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        old_c  = r_vld_rd ? $signed(ram_rdata) : '0;
        old_u  = old_c;
        aold_c = old_c[PW-1] ? (~old_u + 1'b1) : old_u;
        old_x  = SUM_W'(old_c);
        qty_x  = $signed(SUM_W'(r_qty));
        sum_x  = r_side ? (old_x - qty_x) : (old_x + qty_x);
        if (sum_x > SUM_W'(POS_MAX)) begin
            fill_c = POS_MAX;
        end else if (sum_x < SUM_W'(POS_MIN)) begin
            fill_c = POS_MIN;
        end else begin
            fill_c = sum_x[PW-1:0];
        end
        new_u = r_new;
    end

    always_comb begin
        fill_ok_c = r_is_fill && (r_status == plt_pkg::ST_OK);
        write_c   = fill_ok_c || r_is_clear;
        n_exp     = write_c ? r_tot : r_exp;
        n_count   = fill_ok_c ? (r_count + 1'b1) : r_count;
        anew_w    = AC_W'(r_anew);
        peak_cand = (anew_w > AC_W'(plt_pkg::PEAK_MAX)) ? plt_pkg::PEAK_MAX
                                                        : anew_w[plt_pkg::PEAK_W-1:0];
        n_peak    = (fill_ok_c && (peak_cand > r_peak)) ? peak_cand : r_peak;
        exp_w     = CMP_W'(n_exp);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= i_op;
            r_side     <= i_side;
            r_qty      <= i_quantity;
            r_addr     <= raddr_c;
            r_in_range <= in_range_c;
        end
        if (i_cmd.stage_new) begin
            r_old      <= old_c;
            r_aold     <= aold_c;
            r_is_fill  <= r_in_range && (r_op == plt_pkg::OP_FILL);
            r_is_clear <= r_in_range && (r_op == plt_pkg::OP_CLEAR);
            if (r_in_range && (r_op == plt_pkg::OP_FILL)) begin
                r_new <= fill_c;
            end else if (r_in_range && (r_op == plt_pkg::OP_CLEAR)) begin
                r_new <= '0;
            end else begin
                r_new <= old_c;
            end
        end
        if (i_cmd.stage_abs) begin
            r_anew   <= r_new[PW-1] ? (~new_u + 1'b1) : new_u;
            r_others <= r_exp - EXP_W'(r_aold);
        end
        if (i_cmd.stage_sum) begin
            r_pos_fail <= r_risk_on && (AC_W'(r_anew) > AC_W'(r_max_pos));
            r_tot      <= r_others + EXP_W'(r_anew);
        end
        if (i_cmd.decide) begin
            if (r_is_fill && r_pos_fail) begin
                r_status <= plt_pkg::ST_POS_LIMIT;
            end else if (r_is_fill && r_risk_on && (CMP_W'(r_tot) > CMP_W'(r_max_tot))) begin
                r_status <= plt_pkg::ST_TOT_LIMIT;
            end else begin
                r_status <= plt_pkg::ST_OK;
            end
        end
        if (i_cmd.commit) begin
            r_out_status <= r_status;
            r_out_pos    <= (r_status != plt_pkg::ST_OK) ? r_old : r_new;
            r_out_tot    <= (exp_w > CMP_W'(plt_pkg::TOT_OUT_MAX)) ? plt_pkg::TOT_OUT_MAX
                                                                   : exp_w[plt_pkg::MAXTOT_W-1:0];
            r_out_estop  <= (r_status != plt_pkg::ST_OK);
            r_out_count  <= n_count;
            r_out_peak   <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_exp       <= '0;
            r_count     <= '0;
            r_peak      <= '0;
            r_vld_rd    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_vld_rd <= in_range_c && r_valid[raddr_c];
            end
            if (i_cmd.commit) begin
                if (write_c) begin
                    r_valid[r_addr] <= 1'b1;
                end
                r_exp   <= n_exp;
                r_count <= n_count;
                r_peak  <= n_peak;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.position       = r_out_pos;
    assign o_rsp.total_exposure = r_out_tot;
    assign o_rsp.emergency_stop = r_out_estop;
    assign o_rsp.trade_count    = r_out_count;
    assign o_rsp.peak_position  = r_out_peak;

`ifndef SYNTHESIS
    a_reject_keeps_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && (r_status != plt_pkg::ST_OK) |=> $stable(r_exp) && $stable(r_count))
        else $error("rejected fill changed running totals");
    a_estop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_estop == (r_out_status != plt_pkg::ST_OK))
        else $error("emergency stop disagrees with status");
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> o_sts.out_free)
        else $error("result register overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ===== rtl/position_limit_tracker.sv =====
// ============================================================================
// position_limit_tracker
// Pre-trade position risk check over a table of signed per-symbol positions.
// ============================================================================
// Accepted items pass the load, abs, sum, decide and commit states; commit
// registers the result and waits while one is pending. A new item is taken
// only then, as read, check and write-back share the one position memory.
// Synchronous active-low reset clears the valid bits (positions read zero,
// no clearing pass), totals, counters, configuration and valid flags.
`default_nettype none

module position_limit_tracker #(
    parameter int SYMBOL_COUNT   = plt_pkg::SYMBOL_COUNT_DEF,
    parameter int POSITION_WIDTH = plt_pkg::POSITION_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [plt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [plt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    plt_in_if.sink                              i_fill,
    plt_out_if.source                           o_rsp
);

    plt_pkg::t_cmd cmd;
    plt_pkg::t_sts sts;
    logic          in_ready;

    assign i_fill.ready = in_ready;

    plt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_fill.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    plt_datapath #(
        .SYMBOL_COUNT   (SYMBOL_COUNT),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_op       (i_fill.op),
        .i_symbol   (i_fill.symbol),
        .i_side     (i_fill.side),
        .i_quantity (i_fill.quantity),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_rsp      (o_rsp)
    );

endmodule

`default_nettype wire
